// File: hdl/chao_pkg.sv
// Package with the shared types and constants of the Chaocipher letter engine.
package chao_pkg;

  localparam int LETTER_W          = 5;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int ZENITH            = 0;
  localparam int LEFT_EXTRACT      = ZENITH + 1;
  localparam int RIGHT_EXTRACT     = ZENITH + 2;
  localparam int KEY_SEL_W         = 7;

  typedef enum logic [1:0] {
    CMD_LOAD_LEFT  = 2'd0,
    CMD_LOAD_RIGHT = 2'd1,
    CMD_RESTART    = 2'd2,
    CMD_PROCESS    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [LETTER_W-1:0] index;
    logic [LETTER_W-1:0] letter;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_letter;
    logic                not_found;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PERM_A,
    ST_PERM_B,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_RESTART,
    OP_PERM_A,
    OP_PERM_B
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [LETTER_W-1:0] key_letter;
  } cell_ctl_t;

endpackage

// File: hdl/chao_cell.sv
// One disk position: key entries and working entries of both disks.
module chao_cell #(
  parameter int IDX   = 0,
  parameter int NADIR = 13
) (
  input  logic                         clk,
  input  chao_pkg::cell_ctl_t          ctl,
  input  logic                         key_we_left,
  input  logic                         key_we_right,
  input  logic [chao_pkg::LETTER_W-1:0] left_nbr,
  input  logic [chao_pkg::LETTER_W-1:0] right_nbr,
  input  logic [chao_pkg::LETTER_W-1:0] left_held,
  input  logic [chao_pkg::LETTER_W-1:0] right_held,
  output logic [chao_pkg::LETTER_W-1:0] left_q,
  output logic [chao_pkg::LETTER_W-1:0] right_q
);

  logic [chao_pkg::LETTER_W-1:0] key_left_r;
  logic [chao_pkg::LETTER_W-1:0] key_right_r;
  logic [chao_pkg::LETTER_W-1:0] work_left_r, work_left_nxt;
  logic [chao_pkg::LETTER_W-1:0] work_right_r, work_right_nxt;

  always_comb begin
    work_left_nxt  = work_left_r;
    work_right_nxt = work_right_r;
    case (ctl.op)
      chao_pkg::OP_ROTATE: begin
        work_left_nxt  = left_nbr;
        work_right_nxt = right_nbr;
      end
      chao_pkg::OP_RESTART: begin
        work_left_nxt  = key_left_r;
        work_right_nxt = key_right_r;
      end
      chao_pkg::OP_PERM_A: begin
        if (IDX >= chao_pkg::LEFT_EXTRACT && IDX < NADIR) begin
          work_left_nxt = left_nbr;
        end else if (IDX == NADIR) begin
          work_left_nxt = left_held;
        end
        work_right_nxt = right_nbr;
      end
      chao_pkg::OP_PERM_B: begin
        if (IDX >= chao_pkg::RIGHT_EXTRACT && IDX < NADIR) begin
          work_right_nxt = right_nbr;
        end else if (IDX == NADIR) begin
          work_right_nxt = right_held;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we_left) begin
      key_left_r <= ctl.key_letter;
    end
    if (key_we_right) begin
      key_right_r <= ctl.key_letter;
    end
    work_left_r  <= work_left_nxt;
    work_right_r <= work_right_nxt;
  end

  assign left_q  = work_left_r;
  assign right_q = work_right_r;

endmodule

// File: hdl/chaocipher_letter_engine.sv
// Top level of the Chaocipher letter engine: command decode, sequencer and row of disk cells.
//
// The input channel (in_valid, in_stall, in_data) carries commands: load a left or
// right key entry, restart a message, or process a letter. The result channel
// (out_valid, out_stall, out_data) returns one item for every process command and
// nothing for the others. cfg_we with cfg_wdata sets the mode: 0 encrypt, 1 decrypt.
// Loads and restarts complete in the cycle of their transfer. After a letter's
// transfer the sequencer searches: the disks step through the row of cells one
// position per cycle until the letter sits at the zenith, then the disks are
// permuted (PERM_A, then PERM_B) and the result goes to the output register.
// A letter that is not on the disk is reported as not found once the disks have
// turned a full round, which leaves the disks as they were. A new command is taken
// once the sequencer is idle, while an earlier result may still wait in the output
// register. When the receiver stalls, the result holds and the next letter waits
// in its output cycle. Reset clears the sequencer, the output valid and the mode;
// the key and working disks are undefined until loaded and restarted.
module chaocipher_letter_engine #(
  parameter int ALPHABET_SIZE = chao_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  chao_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output chao_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  localparam int NADIR = ALPHABET_SIZE / 2;
  localparam int CNT_W = $clog2(ALPHABET_SIZE);

  chao_pkg::state_t              state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          mode_r;
  logic [chao_pkg::LETTER_W-1:0] letter_r;
  logic [chao_pkg::LETTER_W-1:0] res_letter_r, res_letter_nxt;
  logic                          res_nf_r, res_nf_nxt;
  logic                          out_valid_r;
  chao_pkg::out_item_t           out_data_r;
  logic                          accept;
  logic                          out_load;
  chao_pkg::cell_ctl_t           ctl;
  logic [chao_pkg::LETTER_W-1:0] left_q  [ALPHABET_SIZE];
  logic [chao_pkg::LETTER_W-1:0] right_q [ALPHABET_SIZE];
  logic [chao_pkg::LETTER_W-1:0] search_val;
  logic [chao_pkg::LETTER_W-1:0] other_val;

  assign in_stall   = (state_r != chao_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign search_val = mode_r ? left_q[chao_pkg::ZENITH] : right_q[chao_pkg::ZENITH];
  assign other_val  = mode_r ? right_q[chao_pkg::ZENITH] : left_q[chao_pkg::ZENITH];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    res_letter_nxt = res_letter_r;
    res_nf_nxt     = res_nf_r;
    out_load       = 1'b0;
    ctl.op         = chao_pkg::OP_HOLD;
    ctl.key_letter = in_data.letter;
    unique case (state_r)
      chao_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (chao_pkg::cmd_t'(in_data.command))
            chao_pkg::CMD_RESTART: ctl.op = chao_pkg::OP_RESTART;
            chao_pkg::CMD_PROCESS: begin
              cnt_nxt   = '0;
              state_nxt = chao_pkg::ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      chao_pkg::ST_SEARCH: begin
        if (search_val == letter_r) begin
          res_letter_nxt = other_val;
          res_nf_nxt     = 1'b0;
          ctl.op         = chao_pkg::OP_PERM_A;
          state_nxt      = chao_pkg::ST_PERM_A;
        end else begin
          ctl.op  = chao_pkg::OP_ROTATE;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ALPHABET_SIZE - 1)) begin
            res_letter_nxt = '0;
            res_nf_nxt     = 1'b1;
            state_nxt      = chao_pkg::ST_EMIT;
          end
        end
      end
      chao_pkg::ST_PERM_A: begin
        ctl.op    = chao_pkg::OP_PERM_B;
        state_nxt = chao_pkg::ST_PERM_B;
      end
      chao_pkg::ST_PERM_B: begin
        state_nxt = chao_pkg::ST_EMIT;
      end
      chao_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = chao_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chao_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chao_pkg::ST_IDLE;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      letter_r <= in_data.letter;
    end
    res_letter_r <= res_letter_nxt;
    res_nf_r     <= res_nf_nxt;
    if (out_load) begin
      out_data_r.out_letter <= res_letter_r;
      out_data_r.not_found  <= res_nf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
    logic key_we_left;
    logic key_we_right;
    logic key_sel;

    assign key_sel = (chao_pkg::KEY_SEL_W'(in_data.index) == chao_pkg::KEY_SEL_W'(g));
    assign key_we_left  = accept && key_sel
                          && (in_data.command == chao_pkg::CMD_LOAD_LEFT);
    assign key_we_right = accept && key_sel
                          && (in_data.command == chao_pkg::CMD_LOAD_RIGHT);

    chao_cell #(
      .IDX   (g),
      .NADIR (NADIR)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .key_we_left  (key_we_left),
      .key_we_right (key_we_right),
      .left_nbr     (left_q[(g + 1) % ALPHABET_SIZE]),
      .right_nbr    (right_q[(g + 1) % ALPHABET_SIZE]),
      .left_held    (left_q[chao_pkg::LEFT_EXTRACT]),
      .right_held   (right_q[chao_pkg::RIGHT_EXTRACT]),
      .left_q       (left_q[g]),
      .right_q      (right_q[g])
    );
  end

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == chao_pkg::ST_EMIT))
    else $error("Result appeared without an output cycle.");

  a_nf_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.not_found |-> out_data_r.out_letter == '0)
    else $error("Missing letter must report letter zero.");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == chao_pkg::ST_SEARCH |-> cnt_r <= CNT_W'(ALPHABET_SIZE - 1))
    else $error("Search counter beyond the disk size.");

  a_search_entry: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.command == chao_pkg::CMD_PROCESS |=> state_r == chao_pkg::ST_SEARCH
      && cnt_r == '0)
    else $error("Letter transfer did not start a search.");

endmodule
